### hdl/csma_pkg.sv
// ---------------------------------------------------------------------------
// csma_pkg
// Shared sizes, map entry codes and result status codes of the chained
// sector map allocator.
// ---------------------------------------------------------------------------
`default_nettype none

package csma_pkg;

  localparam int NUM_SLOTS    = 256;
  localparam int SECTOR_BYTES = 4096;
  localparam int MAX_CHAIN    = 64;

  localparam int SLOT_W  = $clog2(NUM_SLOTS);
  localparam int PTR_W   = SLOT_W + 1;
  localparam int FOUND_W = 7;
  localparam int ENTRY_W = 16;
  localparam int LINK_W  = 15;

  localparam logic [ENTRY_W-1:0] ENTRY_FREE = 16'hFFFF;
  localparam logic [LINK_W-1:0]  LINK_BAD   = 15'h7FFF;
  localparam logic [LINK_W-1:0]  LINK_END   = 15'h0000;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_SPACE  = 2'd1,
    ST_NOT_ALLOC = 2'd2,
    ST_BAD_LINK  = 2'd3
  } status_t;

endpackage

`default_nettype wire

### hdl/chained_sector_map_allocator.sv
// ---------------------------------------------------------------------------
// chained_sector_map_allocator
// Sector map allocator: claims and links chains of free slots, frees chains.
// ---------------------------------------------------------------------------
// One request is worked on at a time. An allocate request first counts free
// slots from slot 0, then, on success, makes one more pass from the first free
// slot to the last claimed one to write the links. A free request walks the
// chain entry by entry. The length of both is set by the single read port of
// the map memory. The map comes out of reset all free at once (per-entry valid
// bits), with no clearing pass. The result sits in an output register, so the
// next request is taken while the last result still waits.
`default_nettype none

module chained_sector_map_allocator
  import csma_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [47:0] s_tdata,   // block_bytes[31:0], start_slot[39:32], as_file[40]
  input  wire logic        s_tuser,   // mode
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata    // status[1:0], slot[9:2], slots_found[16:10]
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_COUNT = 6'b000010,
    S_LINK  = 6'b000100,
    S_LAST  = 6'b001000,
    S_WALK  = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t state, state_next;

  logic [PTR_W-1:0]   ptr, ptr_next;
  logic [SLOT_W-1:0]  cur, cur_next;
  logic [SLOT_W-1:0]  head, head_next;
  logic [FOUND_W-1:0] cnt, cnt_next;
  logic [FOUND_W-1:0] target, target_next;
  logic               over, over_next;
  logic               as_file, as_file_next;
  logic               first, first_next;

  status_t      res_status, res_status_next;
  logic [7:0]   res_slot, res_slot_next;
  logic [FOUND_W-1:0] res_found, res_found_next;

  status_t      out_status;
  logic [7:0]   out_slot;
  logic [FOUND_W-1:0] out_found;
  logic         out_load;

  // map memory
  logic [ENTRY_W-1:0] map_mem [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] map_vld;
  logic               rd_en, wr_en;
  logic [SLOT_W-1:0]  rd_addr, wr_addr;
  logic [ENTRY_W-1:0] wr_data;
  logic [ENTRY_W-1:0] rd_q, fwd_data;
  logic               rd_q_vld, fwd_hit;
  logic               q_vld;
  logic [SLOT_W-1:0]  q_addr;

  logic [ENTRY_W-1:0] ent;
  logic [LINK_W-1:0]  link;
  logic               ent_free;
  logic [FOUND_W-1:0] cnt_inc;
  logic               hit;
  logic               at_end;

  logic               in_mode, in_file;
  logic [31:0]        in_bytes;
  logic [7:0]         in_start;
  logic [31:0]        blocks;

  assign in_bytes = s_tdata[31:0];
  assign in_start = s_tdata[39:32];
  assign in_file  = s_tdata[40];
  assign in_mode  = s_tuser;
  assign blocks   = in_bytes / SECTOR_BYTES;

  assign s_tready = (state == S_IDLE);

  // an entry never written reads as free; a same-cycle write wins over old data
  assign ent      = fwd_hit ? fwd_data : (rd_q_vld ? rd_q : ENTRY_FREE);
  assign link     = ent[LINK_W-1:0];
  assign ent_free = (ent == ENTRY_FREE);
  assign cnt_inc  = cnt + FOUND_W'(1);
  assign hit      = q_vld && ent_free;
  assign at_end   = q_vld && (q_addr == SLOT_W'(NUM_SLOTS - 1));

  always_comb begin
    state_next      = state;
    ptr_next        = ptr;
    cur_next        = cur;
    head_next       = head;
    cnt_next        = cnt;
    target_next     = target;
    over_next       = over;
    as_file_next    = as_file;
    first_next      = first;
    res_status_next = res_status;
    res_slot_next   = res_slot;
    res_found_next  = res_found;
    rd_en           = 1'b0;
    rd_addr         = ptr[SLOT_W-1:0];
    wr_en           = 1'b0;
    wr_addr         = cur;
    wr_data         = ENTRY_FREE;
    out_load        = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          if (in_mode) begin
            cur_next   = SLOT_W'(in_start);
            first_next = 1'b1;
            if (32'(in_start) >= NUM_SLOTS) begin
              res_status_next = ST_NOT_ALLOC;
              res_slot_next   = in_start;
              res_found_next  = '0;
              state_next      = S_DONE;
            end else begin
              state_next = S_WALK;
            end
          end else begin
            ptr_next     = '0;
            cnt_next     = '0;
            as_file_next = in_file;
            over_next    = (blocks >= MAX_CHAIN);
            target_next  = (blocks >= MAX_CHAIN) ? FOUND_W'(MAX_CHAIN)
                                                 : FOUND_W'(blocks + 32'd1);
            state_next   = S_COUNT;
          end
        end
      end

      // first pass: count free slots without touching the map
      S_COUNT: begin
        if (hit) begin
          cnt_next = cnt_inc;
          if (cnt == '0) begin
            head_next = q_addr;
          end
        end
        if (hit && (cnt_inc == target)) begin
          if (over) begin
            res_status_next = ST_NO_SPACE;
            res_slot_next   = '0;
            res_found_next  = cnt_inc;
            state_next      = S_DONE;
          end else begin
            ptr_next   = {1'b0, ((cnt == '0) ? q_addr : head)};
            cnt_next   = '0;
            state_next = S_LINK;
          end
        end else if (at_end) begin
          res_status_next = ST_NO_SPACE;
          res_slot_next   = '0;
          res_found_next  = hit ? cnt_inc : cnt;
          state_next      = S_DONE;
        end else if (ptr < PTR_W'(NUM_SLOTS)) begin
          rd_en    = 1'b1;
          ptr_next = ptr + PTR_W'(1);
        end
      end

      // second pass: link each claimed slot to the next free one; S_LAST ends the chain
      S_LINK: begin
        if (hit) begin
          if (cnt != '0) begin
            wr_en   = 1'b1;
            wr_addr = cur;
            wr_data = {(cnt == FOUND_W'(1)) && as_file, LINK_W'(q_addr)};
          end
          cur_next = q_addr;
          cnt_next = cnt_inc;
        end
        if (hit && (cnt_inc == target)) begin
          state_next = S_LAST;
        end else if (ptr < PTR_W'(NUM_SLOTS)) begin
          rd_en    = 1'b1;
          ptr_next = ptr + PTR_W'(1);
        end
      end

      S_LAST: begin
        wr_en           = 1'b1;
        wr_addr         = cur;
        wr_data         = {(target == FOUND_W'(1)) && as_file, LINK_END};
        res_status_next = ST_OK;
        res_slot_next   = 8'(head);
        res_found_next  = target;
        state_next      = S_DONE;
      end

      S_WALK: begin
        res_found_next = '0;
        res_slot_next  = 8'(cur);
        if (q_vld) begin
          first_next = 1'b0;
          if (first && ent_free) begin
            res_status_next = ST_NOT_ALLOC;
            state_next      = S_DONE;
          end else if (link == LINK_END) begin
            wr_en           = 1'b1;
            res_status_next = ST_OK;
            state_next      = S_DONE;
          end else if ((link == LINK_BAD) || (link >= LINK_W'(NUM_SLOTS))) begin
            res_status_next = ST_BAD_LINK;
            state_next      = S_DONE;
          end else begin
            wr_en    = 1'b1;
            cur_next = link[SLOT_W-1:0];
            rd_en    = 1'b1;
            rd_addr  = link[SLOT_W-1:0];
          end
        end else begin
          rd_en   = 1'b1;
          rd_addr = cur;
        end
      end

      S_DONE: begin
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      first <= 1'b0;
    end else begin
      state <= state_next;
      first <= first_next;
    end
    ptr        <= ptr_next;
    cur        <= cur_next;
    head       <= head_next;
    cnt        <= cnt_next;
    target     <= target_next;
    over       <= over_next;
    as_file    <= as_file_next;
    res_status <= res_status_next;
    res_slot   <= res_slot_next;
    res_found  <= res_found_next;
  end

  // map memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      map_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= map_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      map_vld <= '0;
      q_vld   <= 1'b0;
    end else begin
      if (wr_en) begin
        map_vld[wr_addr] <= 1'b1;
      end
      q_vld <= rd_en;
    end
    if (rd_en) begin
      rd_q_vld <= map_vld[rd_addr];
      q_addr   <= rd_addr;
      fwd_hit  <= wr_en && (wr_addr == rd_addr);
      fwd_data <= wr_data;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (out_load) begin
      out_status <= res_status;
      out_slot   <= res_slot;
      out_found  <= res_found;
    end
  end

  assign m_tdata = {7'd0, out_found, out_slot, out_status};

endmodule

`default_nettype wire

### hdl/csma_checker.sv
// ---------------------------------------------------------------------------
// csma_checker
// Port-level checks on the chained sector map allocator, bound to the top.
// ---------------------------------------------------------------------------
`default_nettype none

module csma_checker
  import csma_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [23:0] m_tdata
);

  // a result waiting for the sink must not change
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // one request at a time: taking a request closes the input side
  a_one_req: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second request taken while busy");

  // a failed allocation reports no slot
  a_fail_slot: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[1:0] == ST_NO_SPACE) |-> (m_tdata[9:2] == 8'd0))
    else $error("failed allocation with nonzero slot");

  // free errors never report claimed slots
  a_free_found: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && ((m_tdata[1:0] == ST_NOT_ALLOC) || (m_tdata[1:0] == ST_BAD_LINK))
    |-> (m_tdata[16:10] == 7'd0))
    else $error("free error with slots found");

  // never more than the chain limit
  a_found_max: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[16:10] <= 7'(MAX_CHAIN)))
    else $error("slots found above chain limit");

endmodule

bind chained_sector_map_allocator csma_checker u_csma_checker (.*);

`default_nettype wire
